/* rtl/htmgp_pkg.sv */
// ----------------------------------------------------------------------------
// HDR tone map and gamma pack package
// Shared widths, the alpha byte and the elaboration-time functions that build
// the gamma 2.2 threshold table.
// ----------------------------------------------------------------------------
package htmgp_pkg;

	localparam int CHAN_W = 24;
	localparam int PIX_W = 32;
	localparam int BYTE_W = 8;
	localparam int N_CHAN = 3;
	localparam int GAMMA_LEVELS = 256;
	localparam logic [BYTE_W-1:0] ALPHA_BYTE = 8'hFF;

	// The gamma exponent 1/2.2 is 5/11 and the output scale 255.99 is 25599/100.
	localparam int GAMMA_POW_OUT = 11;
	localparam int GAMMA_POW_IN = 5;
	localparam int SCALE_NUM = 25599;
	localparam int SCALE_DEN = 100;

	localparam int BIG_W = 320;

	function automatic logic gamma_reaches(input int lvl, input int t, input int lut_bits);
		logic [BIG_W-1:0] lhs;
		logic [BIG_W-1:0] rhs;
		lhs = BIG_W'(1);
		rhs = BIG_W'(1);
		for (int i = 0; i < GAMMA_POW_OUT; i++) begin
			lhs = lhs * BIG_W'(SCALE_DEN * lvl);
			rhs = rhs * BIG_W'(SCALE_NUM);
		end
		lhs = lhs << (GAMMA_POW_IN * lut_bits);
		for (int i = 0; i < GAMMA_POW_IN; i++) begin
			rhs = rhs * BIG_W'(t);
		end
		return lhs <= rhs;
	endfunction

	// Smallest tone-mapped code whose gamma byte reaches lvl.
	function automatic int gamma_threshold(input int lvl, input int lut_bits);
		int lo;
		int hi;
		int mid;
		lo = 0;
		hi = 1 << lut_bits;
		if (lvl == 0) begin
			return 0;
		end
		while (lo < hi) begin
			mid = lo + ((hi - lo) >> 1);
			if (gamma_reaches(lvl, mid, lut_bits)) begin
				hi = mid;
			end else begin
				lo = mid + 1;
			end
		end
		return lo;
	endfunction

endpackage

/* rtl/htmgp_if.sv */
// ----------------------------------------------------------------------------
// HDR tone map and gamma pack channels
// Valid/ready item channels for the HDR pixel input and the packed output.
// ----------------------------------------------------------------------------
interface htmgp_in_if;
	import htmgp_pkg::*;

	logic valid;
	logic ready;
	logic [CHAN_W-1:0] hdr_red;
	logic [CHAN_W-1:0] hdr_green;
	logic [CHAN_W-1:0] hdr_blue;

	modport source(output valid, output hdr_red, output hdr_green, output hdr_blue,
		input ready);
	modport sink(input valid, input hdr_red, input hdr_green, input hdr_blue,
		output ready);
endinterface

interface htmgp_out_if;
	import htmgp_pkg::*;

	logic valid;
	logic ready;
	logic [PIX_W-1:0] packed_pixel;

	modport source(output valid, output packed_pixel, input ready);
	modport sink(input valid, input packed_pixel, output ready);
endinterface

/* rtl/hdr_tone_map_gamma_pack_core.sv */
// ----------------------------------------------------------------------------
// HDR tone map and gamma pack core
// One item per cycle unless the output stalls; empty stages still fill during a stall.
// Depth is a one-bit-per-stage divider for x/(x+1) and an 8-step threshold search.
// Asynchronous reset empties every stage; the gamma table is constant logic.
// ----------------------------------------------------------------------------
module hdr_tone_map_gamma_pack_core #(
	parameter int HDR_FRAC_BITS = 16,
	parameter int HDR_INT_BITS = 8,
	parameter int LUT_ADDR_BITS = 12
) (
	input logic clk,
	input logic arst_n,
	htmgp_in_if.sink pix_in,
	htmgp_out_if.source pix_out
);
	import htmgp_pkg::*;

	localparam int X_FULL = HDR_INT_BITS + HDR_FRAC_BITS;
	localparam int XW = (X_FULL < CHAN_W) ? X_FULL : CHAN_W;
	localparam int DW = ((XW > HDR_FRAC_BITS) ? XW : HDR_FRAC_BITS) + 1;
	localparam int TW = LUT_ADDR_BITS + 1;
	localparam int NDIV = LUT_ADDR_BITS;
	localparam int NSRCH = BYTE_W;
	localparam int NS = 1 + NDIV + NSRCH;

	typedef struct packed {
		logic [DW-1:0] rem;
		logic [DW-1:0] den;
		logic [LUT_ADDR_BITS-1:0] quo;
	} div_t;

	typedef struct packed {
		logic [LUT_ADDR_BITS-1:0] t;
		logic [BYTE_W-1:0] lvl;
	} srch_t;

	function automatic div_t div_step(input div_t d);
		div_t r;
		logic [DW:0] sh;
		logic ge;
		sh = {d.rem, 1'b0};
		ge = sh >= {1'b0, d.den};
		r.den = d.den;
		r.rem = ge ? DW'(sh - {1'b0, d.den}) : sh[DW-1:0];
		r.quo = {d.quo[LUT_ADDR_BITS-2:0], ge};
		return r;
	endfunction

	logic [TW-1:0] gamma_thr [GAMMA_LEVELS];
	logic [CHAN_W-1:0] hdr_in [N_CHAN];
	logic [NS-1:0] vld_q;
	logic [NS-1:0] adv;
	div_t div_s [NDIV+1][N_CHAN];
	srch_t srch_s [1:NSRCH][N_CHAN];

	for (genvar v = 0; v < GAMMA_LEVELS; v++) begin : g_thr
		localparam logic [TW-1:0] THR = TW'(gamma_threshold(v, LUT_ADDR_BITS));
		assign gamma_thr[v] = THR;
	end

	assign hdr_in[0] = pix_in.hdr_red;
	assign hdr_in[1] = pix_in.hdr_green;
	assign hdr_in[2] = pix_in.hdr_blue;

	// A stage moves when it is empty or the stage after it moves.
	assign adv[NS-1] = !vld_q[NS-1] || pix_out.ready;
	for (genvar i = 0; i < NS - 1; i++) begin : g_adv
		assign adv[i] = !vld_q[i] || adv[i+1];
	end

	assign pix_in.ready = adv[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) begin
				vld_q[0] <= pix_in.valid;
			end
			for (int i = 1; i < NS; i++) begin
				if (adv[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	for (genvar c = 0; c < N_CHAN; c++) begin : g_in
		logic [XW-1:0] x;
		assign x = hdr_in[c][XW-1:0];
		always_ff @(posedge clk) begin
			if (adv[0]) begin
				div_s[0][c].rem <= DW'(x);
				div_s[0][c].den <= DW'(x) + (DW'(1) << HDR_FRAC_BITS);
				div_s[0][c].quo <= '0;
			end
		end
	end

	for (genvar k = 1; k <= NDIV; k++) begin : g_div
		for (genvar c = 0; c < N_CHAN; c++) begin : g_ch
			always_ff @(posedge clk) begin
				if (adv[k]) begin
					div_s[k][c] <= div_step(div_s[k-1][c]);
				end
			end
		end
	end

	for (genvar j = 1; j <= NSRCH; j++) begin : g_srch
		localparam logic [BYTE_W-1:0] STEP = BYTE_W'(1) << (NSRCH - j);
		for (genvar c = 0; c < N_CHAN; c++) begin : g_ch
			srch_t prev;
			logic [BYTE_W-1:0] cand;
			logic take;
			if (j == 1) begin : g_first
				assign prev = '{t: div_s[NDIV][c].quo, lvl: '0};
			end else begin : g_next
				assign prev = srch_s[j-1][c];
			end
			assign cand = prev.lvl | STEP;
			assign take = gamma_thr[cand] <= {1'b0, prev.t};
			always_ff @(posedge clk) begin
				if (adv[NDIV+j]) begin
					srch_s[j][c].t <= prev.t;
					srch_s[j][c].lvl <= take ? cand : prev.lvl;
				end
			end
		end
	end

	assign pix_out.valid = vld_q[NS-1];
	assign pix_out.packed_pixel = {ALPHA_BYTE, srch_s[NSRCH][2].lvl,
		srch_s[NSRCH][1].lvl, srch_s[NSRCH][0].lvl};

endmodule
